// File: hdl/set_assoc_lru_cache_directory_unit_defines.svh
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_directory_unit_defines
// assertion macros used by the cache directory back end
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_DIRECTORY_UNIT_DEFINES_SVH

// clocked property with a reset guard
`define SACD_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// default clock and reset names of this project
`define SACD_ASSERT(name, prop, msg) \
    `SACD_ASSERT_CLK(name, i_clk, i_rst_n, prop, msg)

`endif

// File: hdl/sacd_pkg.sv
// ----------------------------------------------------------------------------
// sacd_pkg
// types and constants of the set associative lru cache directory
// ----------------------------------------------------------------------------
`default_nettype none

package sacd_pkg;

    localparam int ADDR_W  = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);

    // register slots, decoded from paddr[3:2]
    localparam logic [1:0] REG_BLOCK_SHIFT = 2'd0;
    localparam logic [1:0] REG_SET_SHIFT   = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic [2:0] block_shift;
        logic [2:0] set_shift;
        logic [3:0] ways_in_use;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] aligned;
    } t_item;

    localparam t_cfg CFG_RESET = '{block_shift: 3'd4, set_shift: 3'd6, ways_in_use: 4'd8};

endpackage

`default_nettype wire

// File: hdl/sacd_ram.sv
// ----------------------------------------------------------------------------
// sacd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module sacd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/sacd_front.sv
// ----------------------------------------------------------------------------
// sacd_front
// accepts accesses, aligns the address, picks the set and queues the word
// ----------------------------------------------------------------------------
`default_nettype none

module sacd_front #(
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 32,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sacd_pkg::t_cfg        i_cfg,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [31:0]           i_address,
    output logic                       o_q_valid,
    output sacd_pkg::t_item            o_q_item,
    output logic [SET_W-1:0]           o_q_set,
    input  wire logic                  i_q_pop
);

    import sacd_pkg::*;

    localparam int MAX_SS = $clog2(MAX_SETS + 1) - 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                            : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] blk_num;
    logic [3:0]        eff_ss;
    t_item             item;
    logic [SET_W-1:0]  set_sel;
    logic              accept;

    t_item             r_q_item [Q_DEPTH];
    logic [SET_W-1:0]  r_q_set  [Q_DEPTH];
    logic [Q_PW-1:0]   r_wr_ptr;
    logic [Q_PW-1:0]   r_rd_ptr;
    logic [Q_PW:0]     r_count;
    logic [Q_PW:0]     n_count;

    always_comb begin
        addr_m       = i_address & ADDR_MASK;
        blk_num      = addr_m >> i_cfg.block_shift;
        item.kind    = i_kind;
        item.aligned = addr_m & ({ADDR_W{1'b1}} << i_cfg.block_shift);
        // sets beyond the built count fold down to the largest power of two
        if ({1'b0, i_cfg.set_shift} > 4'(MAX_SS)) begin
            eff_ss = 4'(MAX_SS);
        end else begin
            eff_ss = {1'b0, i_cfg.set_shift};
        end
        set_sel = blk_num[SET_W-1:0] & ~({SET_W{1'b1}} << eff_ss);
    end

    assign o_in_stall = (r_count == (Q_PW + 1)'(Q_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        unique case ({accept, i_q_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_item[r_wr_ptr] <= item;
            r_q_set[r_wr_ptr]  <= set_sel;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q_item[r_rd_ptr];
    assign o_q_set   = r_q_set[r_rd_ptr];

endmodule

`default_nettype wire

// File: hdl/sacd_back.sv
// ----------------------------------------------------------------------------
// sacd_back
// reads the set row, resolves hit, fill or eviction and writes the row back
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_cache_directory_unit_defines.svh"

module sacd_back #(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sacd_pkg::t_cfg    i_cfg,
    input  wire logic              i_dir_clear,
    input  wire logic              i_q_valid,
    input  wire sacd_pkg::t_item   i_q_item,
    input  wire logic [SET_W-1:0]  i_q_set,
    output logic                   o_q_pop,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_hit,
    output logic [5:0]             o_set_index,
    output logic [2:0]             o_way_slot,
    output logic                   o_fill_req,
    output logic                   o_write_through,
    output logic                   o_evicted,
    output logic [31:0]            o_evicted_block,
    output logic [31:0]            o_hit_count,
    output logic [31:0]            o_miss_count
);

    import sacd_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W = WAY_W;
    localparam int TAG_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int ENT_W = 1 + AGE_W + TAG_W;
    localparam int ROW_W = MAX_WAYS * ENT_W;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state             r_state;
    t_item              r_cur_item;
    logic [SET_W-1:0]   r_cur_set;
    logic               r_cur_rowv;
    logic [MAX_SETS-1:0] r_row_valid;

    logic               r_out_valid;
    logic               r_hit;
    logic [5:0]         r_set_index;
    logic [2:0]         r_way_slot;
    logic               r_fetch;
    logic               r_write_through;
    logic               r_evicted;
    logic [31:0]        r_evicted_block;
    logic [31:0]        r_hits;
    logic [31:0]        r_misses;

    logic               rd_issue;
    logic               load;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   new_row;

    logic [4:0]          eff_w;
    logic [TAG_W-1:0]    cur_tag;
    logic [MAX_WAYS-1:0] ent_v;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] lru_vec;
    logic [MAX_WAYS-1:0] inc;
    logic [AGE_W-1:0]    ent_age [MAX_WAYS];
    logic [TAG_W-1:0]    ent_tag [MAX_WAYS];
    logic [WAY_W-1:0]    hit_slot;
    logic [WAY_W-1:0]    inv_slot;
    logic [WAY_W-1:0]    lru_slot;
    logic [WAY_W-1:0]    slot;
    logic [AGE_W-1:0]    slot_age;
    logic                hit;
    logic                found;
    logic                evict;
    logic [31:0]         ev_blk;

    assign rd_issue = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop  = rd_issue;
    assign load     = (r_state == S_LOOK) && (!r_out_valid || !i_out_stall);

    sacd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (load),
        .i_waddr (r_cur_set),
        .i_wdata (new_row),
        .i_re    (rd_issue),
        .i_raddr (i_q_set),
        .o_rdata (row)
    );

    always_comb begin
        logic [ENT_W-1:0] ent;
        if (i_cfg.ways_in_use == 4'd0) begin
            eff_w = 5'd1;
        end else if ({1'b0, i_cfg.ways_in_use} > 5'(MAX_WAYS)) begin
            eff_w = 5'(MAX_WAYS);
        end else begin
            eff_w = {1'b0, i_cfg.ways_in_use};
        end
        cur_tag = r_cur_item.aligned[TAG_W-1:0];

        // a row never written since the last invalidate reads as all empty
        for (int k = 0; k < MAX_WAYS; k++) begin
            ent        = row[k*ENT_W +: ENT_W];
            in_use[k]  = (5'(k) < eff_w);
            ent_v[k]   = r_cur_rowv && ent[ENT_W-1];
            ent_age[k] = r_cur_rowv ? ent[TAG_W +: AGE_W] : '0;
            ent_tag[k] = ent[TAG_W-1:0];
            hit_vec[k] = in_use[k] && ent_v[k] && (ent_tag[k] == cur_tag);
            inv_vec[k] = in_use[k] && !ent_v[k];
            // a full set holds every age once, so the oldest is ways minus one
            lru_vec[k] = in_use[k] && (ent_age[k] == AGE_W'(eff_w - 5'd1));
        end

        hit_slot = '0;
        inv_slot = '0;
        lru_slot = '0;
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (hit_vec[k]) begin
                hit_slot = WAY_W'(k);
            end
            if (inv_vec[k]) begin
                inv_slot = WAY_W'(k);
            end
            if (lru_vec[k]) begin
                lru_slot = WAY_W'(k);
            end
        end

        hit   = |hit_vec;
        found = |inv_vec;
        evict = !hit && !found;
        priority if (hit) begin
            slot = hit_slot;
        end else if (found) begin
            slot = inv_slot;
        end else begin
            slot = lru_slot;
        end
        slot_age = ent_age[slot];
        ev_blk   = evict ? 32'(ent_tag[slot]) : 32'd0;

        for (int k = 0; k < MAX_WAYS; k++) begin
            inc[k] = in_use[k] && ent_v[k] && (WAY_W'(k) != slot)
                     && (!hit || (ent_age[k] < slot_age));
            if (WAY_W'(k) == slot) begin
                new_row[k*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, cur_tag};
            end else begin
                new_row[k*ENT_W +: ENT_W] = {ent_v[k], ent_age[k] + AGE_W'(inc[k]), ent_tag[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // a configuration register write drops every set at once
            if (i_dir_clear) begin
                r_row_valid <= '0;
            end else if (load) begin
                r_row_valid[r_cur_set] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (rd_issue) begin
                        r_cur_item <= i_q_item;
                        r_cur_set  <= i_q_set;
                        r_cur_rowv <= r_row_valid[i_q_set];
                        r_state    <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (load) begin
                        r_hit           <= hit;
                        r_set_index     <= 6'(r_cur_set);
                        r_way_slot      <= 3'(slot);
                        r_fetch         <= !hit;
                        r_write_through <= r_cur_item.kind;
                        r_evicted       <= evict;
                        r_evicted_block <= ev_blk;
                        if (hit) begin
                            r_hits <= r_hits + 32'd1;
                        end else begin
                            r_misses <= r_misses + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_set_index     = r_set_index;
    assign o_way_slot      = r_way_slot;
    assign o_fill_req      = r_fetch;
    assign o_write_through = r_write_through;
    assign o_evicted       = r_evicted;
    assign o_evicted_block = r_evicted_block;
    assign o_hit_count     = r_hits;
    assign o_miss_count    = r_misses;

    `SACD_ASSERT(a_issue_to_look, rd_issue |=> (r_state == S_LOOK), "row read not followed by lookup")
    `SACD_ASSERT(a_one_count_step, load |=> ((r_hits + r_misses) == ($past(r_hits) + $past(r_misses) + 32'd1)), "counters did not advance by one word")
    `SACD_ASSERT(a_hit_excl, r_out_valid |-> ((r_hit ^ r_fetch) && !(r_hit && r_evicted)), "hit flagged with fetch or eviction")
    `SACD_ASSERT(a_row_marked, (load && !i_dir_clear) |=> r_row_valid[$past(r_cur_set)], "written set not marked valid")
    `SACD_ASSERT(a_evict_zero, (r_out_valid && !r_evicted) |-> (r_evicted_block == 32'd0), "victim address without eviction")

endmodule

`default_nettype wire

// File: hdl/set_assoc_lru_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_directory_unit
// tag directory of a set associative write-through cache with true lru
// ----------------------------------------------------------------------------
// Each accepted access (read or write to a byte address) gets one result word
// telling hit or miss, the set and way used, whether the block must be fetched,
// whether a write goes through to memory, and which block, if any, was evicted,
// together with running hit and miss counts. The front end aligns the address
// and picks the set in the accept cycle and parks the word in a two-entry
// queue. The back end owns the single set-row memory (one row per set holding
// tag, valid and age of every way): its idle state reads the row, its lookup
// state compares all ways, updates the ages and writes the row back. It takes
// no new access until the current one leaves the lookup state, which waits
// while an earlier result word is held by the output stall. Any configuration
// register write invalidates the whole directory in the same cycle through one
// valid flag per set, so there is no clearing pass after reset or after
// configuration; hit and miss counters survive register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_directory_unit #(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_address,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic             o_hit,
    output logic [5:0]       o_set_index,
    output logic [2:0]       o_way_slot,
    output logic             o_fill_req,
    output logic             o_write_through,
    output logic             o_evicted,
    output logic [31:0]      o_evicted_block,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_miss_count
);

    import sacd_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic             cfg_wr;
    logic             dir_clear;
    logic             q_valid;
    t_item            q_item;
    logic [SET_W-1:0] q_set;
    logic             q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg     = r_cfg;
        dir_clear = 1'b0;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BLOCK_SHIFT: begin
                    n_cfg.block_shift = pwdata[2:0];
                    dir_clear         = 1'b1;
                end
                REG_SET_SHIFT: begin
                    n_cfg.set_shift = pwdata[2:0];
                    dir_clear       = 1'b1;
                end
                REG_WAYS_IN_USE: begin
                    n_cfg.ways_in_use = pwdata[3:0];
                    dir_clear         = 1'b1;
                end
                default: begin
                    dir_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_SHIFT: prdata = {29'd0, r_cfg.block_shift};
            REG_SET_SHIFT:   prdata = {29'd0, r_cfg.set_shift};
            REG_WAYS_IN_USE: prdata = {28'd0, r_cfg.ways_in_use};
            default:         prdata = 32'd0;
        endcase
    end

    sacd_front #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_address  (i_address),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .o_q_set    (q_set),
        .i_q_pop    (q_pop)
    );

    sacd_back #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_dir_clear     (dir_clear),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .i_q_set         (q_set),
        .o_q_pop         (q_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_hit           (o_hit),
        .o_set_index     (o_set_index),
        .o_way_slot      (o_way_slot),
        .o_fill_req      (o_fill_req),
        .o_write_through (o_write_through),
        .o_evicted       (o_evicted),
        .o_evicted_block (o_evicted_block),
        .o_hit_count     (o_hit_count),
        .o_miss_count    (o_miss_count)
    );

endmodule

`default_nettype wire
